// File: hw/rtl/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

  // Angle and fixed-point constants.
  localparam logic signed [33:0] HALF_PI_Q29  = 34'sd843314857;
  localparam logic signed [33:0] PI_Q29       = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic signed [17:0] PI_Q12       = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12   = 18'sd25736;
  localparam logic signed [15:0] HEAD_TOL_Q12 = 16'sd409;
  localparam logic signed [47:0] ONE_Q8       = 48'sd256;
  localparam logic signed [47:0] FIVE_Q8      = 48'sd1280;

  // Configuration register indexes.
  localparam logic [3:0] REG_TARGET_X       = 4'd0;
  localparam logic [3:0] REG_TARGET_Y       = 4'd1;
  localparam logic [3:0] REG_TARGET_HEADING = 4'd2;
  localparam logic [3:0] REG_GAIN_RANGE     = 4'd3;
  localparam logic [3:0] REG_GAIN_BEARING   = 4'd4;
  localparam logic [3:0] REG_GAIN_DELTA     = 4'd5;
  localparam logic [3:0] REG_STOP_DISTANCE  = 4'd6;
  localparam logic [3:0] REG_WARMUP_STEPS   = 4'd7;

  // Velocity profile codes.
  localparam logic [1:0] PROFILE_SAME = 2'd0;
  localparam logic [1:0] PROFILE_LOW  = 2'd1;
  localparam logic [1:0] PROFILE_HIGH = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_WW, OP_SQRT_W, OP_ATAN_W, OP_THETA, OP_MUL_XX,
    OP_ACC_XX, OP_MUL_YY, OP_SQRT_R, OP_ATAN_B, OP_BRG, OP_SINCOS, OP_MUL_KR,
    OP_MUL_V, OP_V, OP_MUL_SC, OP_MUL_KD, OP_MUL_KSC, OP_MUL_NUM, OP_MUL_KB,
    OP_KB, OP_FINAL
  } dp_op_t;

  typedef struct packed {
    logic sqrt_busy;
    logic cordic_busy;
    logic div_busy;
  } dp_status_t;

  // Arctangent of 2^-i in Q2.29.
  function automatic logic signed [33:0] atan_q29(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sd421657428;
      5'd1:  r = 34'sd248918915;
      5'd2:  r = 34'sd131521918;
      5'd3:  r = 34'sd66762579;
      5'd4:  r = 34'sd33510843;
      5'd5:  r = 34'sd16771758;
      5'd6:  r = 34'sd8387925;
      5'd7:  r = 34'sd4194219;
      5'd8:  r = 34'sd2097141;
      5'd9:  r = 34'sd1048575;
      5'd10: r = 34'sd524288;
      5'd11: r = 34'sd262144;
      5'd12: r = 34'sd131072;
      5'd13: r = 34'sd65536;
      5'd14: r = 34'sd32768;
      5'd15: r = 34'sd16384;
      5'd16: r = 34'sd8192;
      5'd17: r = 34'sd4096;
      5'd18: r = 34'sd2048;
      5'd19: r = 34'sd1024;
      5'd20: r = 34'sd512;
      5'd21: r = 34'sd256;
      5'd22: r = 34'sd128;
      5'd23: r = 34'sd64;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Wraps a Q3.12 angle into [-pi, pi); inputs stay within three half turns.
  function automatic logic signed [17:0] norm_q12(input logic signed [17:0] t);
    logic signed [17:0] r;
    r = t;
    for (int k = 0; k < 2; k++) begin
      if (r >= PI_Q12) begin
        r = r - TWO_PI_Q12;
      end else if (r < -PI_Q12) begin
        r = r + TWO_PI_Q12;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ppc_isqrt.sv
`default_nettype none
module ppc_isqrt import ppc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] radicand,
  output logic             busy,
  output logic [16:0]      root
);

  logic [33:0] rem;
  logic [34:0] res;
  logic [33:0] bitv;
  logic [34:0] trial;

  assign trial = res + {1'b0, bitv};
  assign root  = res[16:0];

  // One result bit per cycle, starting from the top power of four.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= {2'b01, 32'd0};
      busy <= 1'b1;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= 34'({1'b0, rem} - trial);
        res <= (res >> 1) + {1'b0, bitv};
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv == 34'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ppc_cordic.sv
`default_nettype none
module ppc_cordic import ppc_pkg::*; #(
  parameter int ITERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               rotate,
  input  wire logic signed [33:0] x0,
  input  wire logic signed [33:0] y0,
  input  wire logic signed [33:0] z0,
  output logic                    busy,
  output logic signed [33:0]      x_out,
  output logic signed [33:0]      y_out,
  output logic signed [33:0]      z_out
);

  localparam int CW = $clog2(ITERS);

  logic signed [33:0] x, y, z, xs, ys, ang;
  logic [CW-1:0]      cnt;
  logic               rot_mode, neg, zero_vec, up;

  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = atan_q29(5'(cnt));
  assign up  = rot_mode ? (z >= 0) : !(y > 0);

  assign x_out = neg ? -x : x;
  assign y_out = neg ? -y : y;
  assign z_out = zero_vec ? 34'sd0 : z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rot_mode <= rotate;
      if (rotate) begin
        // Fold the angle into the right half plane.
        x        <= x0;
        y        <= y0;
        zero_vec <= 1'b0;
        if (z0 > HALF_PI_Q29) begin
          z   <= z0 - PI_Q29;
          neg <= 1'b1;
        end else if (z0 < -HALF_PI_Q29) begin
          z   <= z0 + PI_Q29;
          neg <= 1'b1;
        end else begin
          z   <= z0;
          neg <= 1'b0;
        end
      end else begin
        neg      <= 1'b0;
        zero_vec <= (x0 == 0) && (y0 == 0);
        if (x0 < 0) begin
          if (y0 >= 0) begin
            x <= y0;
            y <= -x0;
            z <= HALF_PI_Q29;
          end else begin
            x <= -y0;
            y <= x0;
            z <= -HALF_PI_Q29;
          end
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end
    end else if (busy) begin
      if (up) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
      if (cnt == CW'(ITERS - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ppc_divider.sv
`default_nettype none
module ppc_divider import ppc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [41:0] dividend,
  input  wire logic [13:0] divisor,
  output logic             busy,
  output logic [41:0]      quotient
);

  logic [13:0] rem;
  logic [13:0] dvs;
  logic [5:0]  cnt;
  logic [14:0] sh;
  logic        fits;

  assign sh       = {rem, quotient[41]};
  assign fits     = sh >= {1'b0, dvs};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      rem      <= fits ? 14'(sh - {1'b0, dvs}) : sh[13:0];
      quotient <= {quotient[40:0], fits};
      if (cnt == 6'd41) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 6'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ppc_datapath.sv
`default_nettype none
module ppc_datapath import ppc_pkg::*; #(
  parameter int CORDIC_ITERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_op_t             op,
  output dp_status_t              status,
  input  wire logic               cfg_write,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] orient_w,
  output logic signed [15:0]      linear_vel,
  output logic signed [19:0]      angular_vel,
  output logic [1:0]              profile_case,
  output logic                    moving
);

  logic signed [15:0] tgt_x, tgt_y;
  logic signed [14:0] tgt_hd;
  logic [15:0]        k1, k2, k3, stop_dist;
  logic [7:0]         warmup, step_count;

  logic signed [15:0] ow_r, theta, brg, sn_r, cs_r, sc_r;
  logic signed [16:0] dx_r, dy_r, delta;
  logic signed [67:0] prod;
  logic [33:0]        sumsq;
  logic [16:0]        rho_r;
  logic signed [27:0] v_r;
  logic signed [33:0] a_r;
  logic signed [47:0] term0;
  logic signed [23:0] kb_r;
  logic               q_neg;

  logic signed [33:0] mul_a, mul_b;
  logic               mul_en;

  logic               sq_start, sq_busy;
  logic [33:0]        sq_in;
  logic [16:0]        root;

  logic               cd_start, cd_rot, cd_busy;
  logic signed [33:0] cx0, cy0, cz0, cx, cy, cz;
  logic signed [16:0] zq;

  logic               dv_start, dv_busy;
  logic [67:0]        prod_abs;
  logic [15:0]        brg_abs;
  logic [41:0]        quo;
  logic               brg_zero;

  logic signed [15:0] ow_clamp;
  logic signed [47:0] term, w_full, v_full, fv, fw;
  logic [27:0]        av;
  logic [47:0]        aw;
  logic [50:0]        five_aw, five_av;
  logic               drive;
  logic [1:0]         pcase;

  assign status = '{sqrt_busy: sq_busy, cordic_busy: cd_busy, div_busy: dv_busy};

  assign brg_zero = (brg == 16'sd0);
  assign prod_abs = prod[67] ? 68'(-prod) : 68'(prod);
  assign brg_abs  = brg[15] ? 16'(-brg) : 16'(brg);
  assign zq       = 17'((cz + 34'sd65536) >>> 17);

  assign ow_clamp = (orient_w > 16'sd16384) ? 16'sd16384 :
                    (orient_w < -16'sd16384) ? -16'sd16384 : orient_w;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_MUL_WW:  begin mul_a = 34'(ow_r);  mul_b = 34'(ow_r); end
      OP_MUL_XX:  begin mul_a = 34'(dx_r);  mul_b = 34'(dx_r); end
      OP_MUL_YY:  begin mul_a = 34'(dy_r);  mul_b = 34'(dy_r); end
      OP_MUL_KR:  begin mul_a = 34'(k1);    mul_b = 34'(rho_r); end
      OP_MUL_V:   begin mul_a = $signed(prod[33:0]); mul_b = 34'(cs_r); end
      OP_MUL_SC:  begin mul_a = 34'(sn_r);  mul_b = 34'(cs_r); end
      OP_MUL_KD:  begin mul_a = 34'(k3);    mul_b = 34'(delta); end
      OP_MUL_KSC: begin mul_a = 34'(k1);    mul_b = 34'(sc_r); end
      OP_MUL_NUM: begin
        mul_a = brg_zero ? 34'(k1) : $signed(prod[33:0]);
        mul_b = a_r;
      end
      OP_MUL_KB:  begin mul_a = 34'(k2);    mul_b = 34'(brg); end
      default:    mul_en = 1'b0;
    endcase
  end

  // Start strobes and operands for the iterative units.
  always_comb begin
    sq_start = (op == OP_SQRT_W) || (op == OP_SQRT_R);
    sq_in    = (op == OP_SQRT_W) ? 34'(34'd268435456 - prod[33:0])
                                 : 34'(sumsq + prod[33:0]);
    cd_start = (op == OP_ATAN_W) || (op == OP_ATAN_B) || (op == OP_SINCOS);
    cd_rot   = (op == OP_SINCOS);
    cx0      = '0;
    cy0      = '0;
    cz0      = '0;
    case (op)
      OP_ATAN_W: begin
        cx0 = 34'(ow_r) <<< 12;
        cy0 = $signed(34'(root)) <<< 12;
      end
      OP_ATAN_B: begin
        cx0 = 34'(dx_r) <<< 12;
        cy0 = 34'(dy_r) <<< 12;
      end
      OP_SINCOS: begin
        cx0 = CORDIC_K_Q30;
        cz0 = 34'(brg) <<< 17;
      end
      default: ;
    endcase
    dv_start = (op == OP_MUL_KB) && !brg_zero;
  end

  // Output shaping: curvature profile, stop condition and saturation.
  always_comb begin
    term    = brg_zero ? term0 : (q_neg ? -48'(quo) : 48'(quo));
    w_full  = 48'(kb_r) + term;
    v_full  = 48'(v_r);
    av      = v_r[27] ? 28'(-v_r) : 28'(v_r);
    aw      = w_full[47] ? 48'(-w_full) : 48'(w_full);
    five_aw = (51'(aw) << 2) + 51'(aw);
    five_av = (51'(av) << 2) + 51'(av);
    drive   = (rho_r > 17'(stop_dist)) || (theta > HEAD_TOL_Q12) ||
              (step_count < warmup);
    pcase   = PROFILE_SAME;
    if (v_r == 28'sd0) begin
      if (w_full != 48'sd0) pcase = PROFILE_HIGH;
    end else if (five_aw <= 51'(av)) begin
      pcase = PROFILE_LOW;
    end else if (51'(aw) >= five_av) begin
      pcase = PROFILE_HIGH;
    end
    fv = v_full;
    fw = w_full;
    if (pcase == PROFILE_LOW) begin
      fv = FIVE_Q8;
      fw = ONE_Q8;
    end else if (pcase == PROFILE_HIGH) begin
      fv = ONE_Q8;
      fw = ONE_Q8;
    end
    if (fv > 48'sd32767) fv = 48'sd32767;
    else if (fv < -48'sd32768) fv = -48'sd32768;
    if (fw > 48'sd524287) fw = 48'sd524287;
    else if (fw < -48'sd524288) fw = -48'sd524288;
    if (!drive) begin
      fv    = '0;
      fw    = '0;
      pcase = PROFILE_SAME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_x      <= -16'sd4608;
      tgt_y      <= -16'sd4608;
      tgt_hd     <= '0;
      k1         <= 16'd128;
      k2         <= 16'd1024;
      k3         <= 16'd5120;
      stop_dist  <= 16'd128;
      warmup     <= 8'd50;
      step_count <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET_X:       tgt_x     <= cfg_data;
          REG_TARGET_Y:       tgt_y     <= cfg_data;
          REG_TARGET_HEADING: tgt_hd    <= cfg_data[14:0];
          REG_GAIN_RANGE:     k1        <= cfg_data;
          REG_GAIN_BEARING:   k2        <= cfg_data;
          REG_GAIN_DELTA:     k3        <= cfg_data;
          REG_STOP_DISTANCE:  stop_dist <= cfg_data;
          REG_WARMUP_STEPS:   warmup    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (op == OP_FINAL && step_count != 8'hFF) begin
        step_count <= step_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (op)
      OP_LOAD: begin
        ow_r <= ow_clamp;
        dx_r <= 17'(pos_x) - 17'(tgt_x);
        dy_r <= 17'(pos_y) - 17'(tgt_y);
      end
      OP_THETA:   theta <= 16'(norm_q12((18'(zq) <<< 1) - 18'(tgt_hd)));
      OP_ACC_XX:  sumsq <= prod[33:0];
      OP_ATAN_B:  rho_r <= root;
      OP_BRG:     brg <= 16'(norm_q12(18'(zq) - 18'(theta) + PI_Q12));
      OP_SINCOS:  delta <= 17'(brg) + 17'(theta);
      OP_MUL_KR: begin
        sn_r <= 16'((cy + 34'sd32768) >>> 16);
        cs_r <= 16'((cx + 34'sd32768) >>> 16);
      end
      OP_V:       v_r <= 28'((prod + 68'sd2097152) >>> 22);
      OP_MUL_KD:  sc_r <= 16'((prod + 68'sd8192) >>> 14);
      OP_MUL_KSC: a_r <= (34'(brg) <<< 8) + $signed(prod[33:0]);
      OP_MUL_KB: begin
        term0 <= 48'((prod + 68'sd524288) >>> 20);
        q_neg <= prod[67] ^ brg[15];
      end
      OP_KB:      kb_r <= 24'((prod + 68'sd2048) >>> 12);
      OP_FINAL: begin
        linear_vel   <= 16'(fv);
        angular_vel  <= 20'(fw);
        profile_case <= pcase;
        moving       <= drive;
      end
      default: ;
    endcase
  end

  ppc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .busy     (sq_busy),
    .root     (root)
  );

  ppc_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cd_start),
    .rotate (cd_rot),
    .x0     (cx0),
    .y0     (cy0),
    .z0     (cz0),
    .busy   (cd_busy),
    .x_out  (cx),
    .y_out  (cy),
    .z_out  (cz)
  );

  ppc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (prod_abs[63:22]),
    .divisor  (brg_abs[13:0]),
    .busy     (dv_busy),
    .quotient (quo)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ppc_ctrl.sv
`default_nettype none
module ppc_ctrl import ppc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_op_t          op,
  input  wire dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_WW, S_SQRT_W, S_WAIT_SQW, S_ATAN_W, S_WAIT_ATW, S_THETA,
    S_MUL_XX, S_ACC_XX, S_MUL_YY, S_SQRT_R, S_WAIT_SQR, S_ATAN_B, S_WAIT_ATB,
    S_BRG, S_SINCOS, S_WAIT_SC, S_MUL_KR, S_MUL_V, S_V, S_MUL_SC, S_MUL_KD,
    S_MUL_KSC, S_MUL_NUM, S_MUL_KB, S_KB, S_WAIT_DIV, S_FINAL
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:     op = in_valid ? OP_LOAD : OP_NONE;
      S_MUL_WW:   op = OP_MUL_WW;
      S_SQRT_W:   op = OP_SQRT_W;
      S_ATAN_W:   op = OP_ATAN_W;
      S_THETA:    op = OP_THETA;
      S_MUL_XX:   op = OP_MUL_XX;
      S_ACC_XX:   op = OP_ACC_XX;
      S_MUL_YY:   op = OP_MUL_YY;
      S_SQRT_R:   op = OP_SQRT_R;
      S_ATAN_B:   op = OP_ATAN_B;
      S_BRG:      op = OP_BRG;
      S_SINCOS:   op = OP_SINCOS;
      S_MUL_KR:   op = OP_MUL_KR;
      S_MUL_V:    op = OP_MUL_V;
      S_V:        op = OP_V;
      S_MUL_SC:   op = OP_MUL_SC;
      S_MUL_KD:   op = OP_MUL_KD;
      S_MUL_KSC:  op = OP_MUL_KSC;
      S_MUL_NUM:  op = OP_MUL_NUM;
      S_MUL_KB:   op = OP_MUL_KB;
      S_KB:       op = OP_KB;
      S_FINAL:    op = out_free ? OP_FINAL : OP_NONE;
      default:    op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:     if (in_valid) state <= S_MUL_WW;
        S_MUL_WW:   state <= S_SQRT_W;
        S_SQRT_W:   state <= S_WAIT_SQW;
        S_WAIT_SQW: if (!status.sqrt_busy) state <= S_ATAN_W;
        S_ATAN_W:   state <= S_WAIT_ATW;
        S_WAIT_ATW: if (!status.cordic_busy) state <= S_THETA;
        S_THETA:    state <= S_MUL_XX;
        S_MUL_XX:   state <= S_ACC_XX;
        S_ACC_XX:   state <= S_MUL_YY;
        S_MUL_YY:   state <= S_SQRT_R;
        S_SQRT_R:   state <= S_WAIT_SQR;
        S_WAIT_SQR: if (!status.sqrt_busy) state <= S_ATAN_B;
        S_ATAN_B:   state <= S_WAIT_ATB;
        S_WAIT_ATB: if (!status.cordic_busy) state <= S_BRG;
        S_BRG:      state <= S_SINCOS;
        S_SINCOS:   state <= S_WAIT_SC;
        S_WAIT_SC:  if (!status.cordic_busy) state <= S_MUL_KR;
        S_MUL_KR:   state <= S_MUL_V;
        S_MUL_V:    state <= S_V;
        S_V:        state <= S_MUL_SC;
        S_MUL_SC:   state <= S_MUL_KD;
        S_MUL_KD:   state <= S_MUL_KSC;
        S_MUL_KSC:  state <= S_MUL_NUM;
        S_MUL_NUM:  state <= S_MUL_KB;
        S_MUL_KB:   state <= S_KB;
        S_KB:       state <= S_WAIT_DIV;
        S_WAIT_DIV: if (!status.div_busy) state <= S_FINAL;
        S_FINAL:    if (out_free) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/polar_posture_controller_top.sv
`default_nettype none
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   pos_x, pos_y, orient_w
// output    out        out_valid/out_stall linear_vel, angular_vel, profile_case, moving
// config    in         cfg_write           cfg_index, cfg_data
//
// Each accepted word makes three passes through the shared CORDIC unit, two
// through the bit-serial square root and one through the divider, with the
// other datapath operations in between; when the bearing is zero the divider
// is skipped. The controller returns to idle once the result is written and
// only then accepts the next input word.
// Reset is synchronous and active high; it restores the register defaults and
// clears the step counter. A finished word waits in the output register while
// the next input word is accepted and processed; only the final write-back
// waits for out_stall to drop.
module polar_posture_controller_top import ppc_pkg::*; #(
  parameter int CORDIC_ITERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] orient_w,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      linear_vel,
  output logic signed [19:0]      angular_vel,
  output logic [1:0]              profile_case,
  output logic                    moving,
  input  wire logic               cfg_write,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // The controller sequences one datapath operation per cycle, but parks in wait
  // states while an iterative unit is busy or the output is stalled.
  dp_op_t     op;
  dp_status_t status;

  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .status    (status)
  );

  // The datapath holds the configuration registers, the step counter, the
  // shared multiplier, the CORDIC, square-root and divider units, and the
  // output register.
  ppc_datapath #(.CORDIC_ITERS(CORDIC_ITERS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .orient_w     (orient_w),
    .linear_vel   (linear_vel),
    .angular_vel  (angular_vel),
    .profile_case (profile_case),
    .moving       (moving)
  );

endmodule
`default_nettype wire
